// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the field parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked out of reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dip_pkg.sv =====
// ----------------------------------------------------------------------------
// dip_pkg
// Types, codes and the per-byte conversion step of the field parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dip_pkg;

    localparam int MAX_FIELD_CHARS = 12;
    localparam int SEP_REG_BYTES   = 4;
    localparam int CNT_W           = 5;
    localparam logic [CNT_W-1:0] COUNT_CAP = 5'd31;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = PTR_W + 1;

    localparam int CFG_INDEX_W = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SEPARATOR_BYTES  = 2'd0,
        CFG_SEPARATOR_LENGTH = 2'd1,
        CFG_MAX_FIELDS       = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_VALUE = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_DONE  = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_HALT   = 2'd2
    } conv_phase_t;

    typedef struct packed {
        conv_phase_t        phase;
        logic               neg;
        logic signed [31:0] value;
    } conv_t;

    localparam conv_t CONV_CLEAR = '{phase: PH_SKIP, neg: 1'b0, value: 32'sd0};

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        result_kind_t       result_kind;
        logic [15:0]        field_index;
        logic signed [31:0] field_value;
        logic [15:0]        field_count;
        logic               parse_error;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_req_t;

    function automatic conv_t conv_step(input conv_t cur, input logic [7:0] c);
        conv_t       nxt;
        logic        is_digit;
        logic        is_space;
        logic [31:0] d;
        logic [31:0] acc;
        logic [31:0] times_ten;
        nxt       = cur;
        is_digit  = c inside {[CH_ZERO:CH_NINE]};
        is_space  = c inside {[CH_TAB:CH_CR], CH_SPACE};
        d         = {24'd0, 8'(c - CH_ZERO)};
        acc       = cur.value;
        times_ten = (acc << 3) + (acc << 1);
        case (cur.phase)
            PH_SKIP: begin
                if (is_space) begin
                    nxt.phase = PH_SKIP;
                end else if (c == CH_PLUS) begin
                    nxt.phase = PH_DIGITS;
                end else if (c == CH_MINUS) begin
                    nxt.neg   = 1'b1;
                    nxt.phase = PH_DIGITS;
                end else if (is_digit) begin
                    nxt.value = $signed(d);
                    nxt.phase = PH_DIGITS;
                end else begin
                    nxt.phase = PH_HALT;
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    nxt.value = cur.neg ? $signed(times_ten - d) : $signed(times_ten + d);
                end else begin
                    nxt.phase = PH_HALT;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
        return nxt;
    endfunction

endpackage

// ===== hw/rtl/dip_result_queue.sv =====
// ----------------------------------------------------------------------------
// dip_result_queue
// Four-entry result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dip_result_queue
    import dip_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  push_req_t push,
    output logic      room_for_two,
    output logic      m_valid,
    input  logic      m_ready,
    output result_t   m_data
);

    result_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;
    logic              push_fits;

    assign m_valid      = (count_reg != '0);
    assign m_data       = entry_reg[rd_ptr_reg];
    assign pop          = m_valid && m_ready;
    assign room_for_two = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push.n) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.n == 2'd2) begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    assign push_fits = (count_reg + QCNT_W'(push.n)) <= QCNT_W'(QUEUE_DEPTH);

    `ASSERT_PROP(a_push_fits, aclk, aresetn, push_fits, "result queue overflow")

endmodule

// ===== hw/rtl/delimited_integer_field_parser_unit.sv =====
// ----------------------------------------------------------------------------
// delimited_integer_field_parser_unit
// Results of an accepted request are registered in the result queue and read out on m_.
// Throughput: one byte per cycle; a byte yields at most two results, and
// s_ready drops while the four-entry result queue has fewer than two free slots.
// Reset (synchronous, active low) restores the register defaults and clears
// all parse state and the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module delimited_integer_field_parser_unit
    import dip_pkg::*;
#(
    parameter int MAX_SEPARATOR_BYTES = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output result_t                m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [31:0]            cfg_wr_data
);

    localparam int SEP_LEN_W = $clog2(MAX_SEPARATOR_BYTES + 1);
    localparam int SEP_IDX_W = (MAX_SEPARATOR_BYTES > 1) ? $clog2(MAX_SEPARATOR_BYTES) : 1;

    logic [31:0]          sep_bytes_reg;
    logic [2:0]           sep_length_reg;
    logic [15:0]          max_fields_reg;

    logic [7:0]           recent_reg [MAX_SEPARATOR_BYTES];
    logic [7:0]           recent_next [MAX_SEPARATOR_BYTES];
    logic [7:0]           recent_new [MAX_SEPARATOR_BYTES];
    logic [7:0]           sep_byte [MAX_SEPARATOR_BYTES];
    logic [MAX_SEPARATOR_BYTES-1:0] sep_cmp;
    logic [CNT_W-1:0]     count_reg, count_next, count_inc;
    conv_t                commit_reg, commit_next;
    conv_t                full_reg, full_next;
    logic [15:0]          fields_used_reg, fields_next;
    logic                 stopped_reg, stopped_next;
    logic                 error_reg, error_next;

    logic [SEP_LEN_W-1:0] sep_len;
    logic [7:0]           commit_byte;
    logic                 sep_match;
    logic                 accept;
    logic                 step_active;
    logic                 eos_active;
    logic                 field_valid, done_valid;
    result_t              field_res, done_res;
    push_req_t            push;
    logic                 room_for_two;

    logic                 pushing;
    logic                 eos_request;
    logic                 done_pushed;
    logic                 done_first;
    logic                 string_clear;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_bytes_reg  <= 32'd44;
            sep_length_reg <= 3'd1;
            max_fields_reg <= 16'd16;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_SEPARATOR_BYTES:  sep_bytes_reg  <= cfg_wr_data;
                CFG_SEPARATOR_LENGTH: sep_length_reg <= cfg_wr_data[2:0];
                CFG_MAX_FIELDS:       max_fields_reg <= cfg_wr_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (sep_length_reg == 3'd0) begin
            sep_len = SEP_LEN_W'(1);
        end else if (int'(sep_length_reg) > MAX_SEPARATOR_BYTES) begin
            sep_len = SEP_LEN_W'(MAX_SEPARATOR_BYTES);
        end else begin
            sep_len = SEP_LEN_W'(sep_length_reg);
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SEPARATOR_BYTES; g++) begin : g_sep
            if (g < SEP_REG_BYTES) begin : g_cfg
                assign sep_byte[g] = sep_bytes_reg[8*g +: 8];
            end else begin : g_zero
                assign sep_byte[g] = 8'd0;
            end
            if (g == 0) begin : g_head
                assign recent_new[g] = s_data.char_byte;
            end else begin : g_tail
                assign recent_new[g] = recent_reg[g-1];
            end
            assign sep_cmp[g] = (SEP_LEN_W'(g) >= sep_len) ||
                (recent_new[g] ==
                 sep_byte[SEP_IDX_W'(sep_len - SEP_LEN_W'(1) - SEP_LEN_W'(g))]);
        end
    endgenerate

    assign count_inc   = (count_reg == COUNT_CAP) ? count_reg : count_reg + CNT_W'(1);
    assign sep_match   = (&sep_cmp) && (count_inc >= CNT_W'(sep_len));
    assign commit_byte = recent_new[SEP_IDX_W'(sep_len - SEP_LEN_W'(1))];
    assign accept      = s_valid && s_ready;
    assign step_active = !stopped_reg && (fields_used_reg < max_fields_reg);
    assign s_ready     = room_for_two;

    always_comb begin
        recent_next  = recent_reg;
        count_next   = count_reg;
        commit_next  = commit_reg;
        full_next    = full_reg;
        fields_next  = fields_used_reg;
        stopped_next = stopped_reg;
        error_next   = error_reg;
        field_valid  = 1'b0;
        field_res    = '0;
        done_valid   = 1'b0;
        done_res     = '0;
        eos_active   = 1'b0;
        if (accept) begin
            if (step_active) begin
                if (s_data.char_byte == CH_NUL) begin
                    if (count_reg != '0) begin
                        if (count_reg > CNT_W'(MAX_FIELD_CHARS)) begin
                            error_next = 1'b1;
                        end else begin
                            field_valid             = 1'b1;
                            field_res.result_kind   = KIND_VALUE;
                            field_res.field_index   = fields_used_reg;
                            field_res.field_value   = full_reg.value;
                            fields_next             = fields_used_reg + 16'd1;
                        end
                    end
                    commit_next  = CONV_CLEAR;
                    full_next    = CONV_CLEAR;
                    count_next   = '0;
                    stopped_next = 1'b1;
                end else begin
                    recent_next = recent_new;
                    count_next  = count_inc;
                    if (sep_match) begin
                        field_valid           = 1'b1;
                        field_res.field_index = fields_used_reg;
                        if (count_inc == CNT_W'(sep_len)) begin
                            field_res.result_kind = KIND_EMPTY;
                        end else begin
                            field_res.result_kind = KIND_VALUE;
                            field_res.field_value = commit_reg.value;
                        end
                        fields_next = fields_used_reg + 16'd1;
                        commit_next = CONV_CLEAR;
                        full_next   = CONV_CLEAR;
                        count_next  = '0;
                        if (fields_next >= max_fields_reg) begin
                            stopped_next = 1'b1;
                        end
                    end else begin
                        full_next = conv_step(full_reg, s_data.char_byte);
                        if (count_inc >= CNT_W'(sep_len)) begin
                            commit_next = conv_step(commit_reg, commit_byte);
                            if (CNT_W'(count_inc - CNT_W'(sep_len)) >=
                                CNT_W'(MAX_FIELD_CHARS)) begin
                                error_next   = 1'b1;
                                stopped_next = 1'b1;
                            end
                        end
                    end
                end
            end
            if (s_data.end_of_string) begin
                eos_active = !stopped_next && (fields_next < max_fields_reg);
                if (eos_active && (count_next != '0)) begin
                    if (count_next > CNT_W'(MAX_FIELD_CHARS)) begin
                        error_next = 1'b1;
                    end else begin
                        field_valid           = 1'b1;
                        field_res.result_kind = KIND_VALUE;
                        field_res.field_index = fields_next;
                        field_res.field_value = full_next.value;
                        fields_next           = fields_next + 16'd1;
                    end
                end
                done_valid           = 1'b1;
                done_res.result_kind = KIND_DONE;
                done_res.field_count = fields_next;
                done_res.parse_error = error_next;
                done_res.last_result = 1'b1;
                for (int i = 0; i < MAX_SEPARATOR_BYTES; i++) begin
                    recent_next[i] = 8'd0;
                end
                count_next   = '0;
                commit_next  = CONV_CLEAR;
                full_next    = CONV_CLEAR;
                fields_next  = 16'd0;
                stopped_next = 1'b0;
                error_next   = 1'b0;
            end
        end
    end

    always_comb begin
        push.n      = {field_valid & done_valid, field_valid ^ done_valid};
        push.first  = field_valid ? field_res : done_res;
        push.second = done_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SEPARATOR_BYTES; i++) begin
                recent_reg[i] <= 8'd0;
            end
            count_reg       <= '0;
            commit_reg      <= CONV_CLEAR;
            full_reg        <= CONV_CLEAR;
            fields_used_reg <= 16'd0;
            stopped_reg     <= 1'b0;
            error_reg       <= 1'b0;
        end else begin
            recent_reg      <= recent_next;
            count_reg       <= count_next;
            commit_reg      <= commit_next;
            full_reg        <= full_next;
            fields_used_reg <= fields_next;
            stopped_reg     <= stopped_next;
            error_reg       <= error_next;
        end
    end

    dip_result_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .room_for_two (room_for_two),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    assign pushing      = (push.n != 2'd0);
    assign eos_request  = accept && s_data.end_of_string;
    assign done_pushed  = (push.n == 2'd1 && push.first.result_kind == KIND_DONE) ||
                          (push.n == 2'd2 && push.second.result_kind == KIND_DONE);
    assign done_first   = (push.n == 2'd2) && (push.first.result_kind == KIND_DONE);
    assign string_clear = (fields_used_reg == 16'd0) && !stopped_reg && !error_reg;

    `ASSERT_IMPLIES(a_push_needs_request, aclk, aresetn, pushing, accept, "result without request")
    `ASSERT_IMPLIES(a_eos_gives_done, aclk, aresetn, eos_request, done_pushed, "no done result")
    `ASSERT_PROP(a_done_is_last, aclk, aresetn, !done_first, "done result ahead of field result")
    `ASSERT_NEXT(a_fresh_after_eos, aclk, aresetn, eos_request, string_clear, "state not cleared")

endmodule
